/* hdl/multichannel_adc_key_debounce_macros.svh */
// Assertion macros for the multichannel ADC key debounce block
`ifndef MULTICHANNEL_ADC_KEY_DEBOUNCE_MACROS_SVH
`define MULTICHANNEL_ADC_KEY_DEBOUNCE_MACROS_SVH

// same-cycle implication, quiet during reset
`define MKDB_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mkdb check failed");

// next-cycle implication, quiet during reset
`define MKDB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mkdb check failed");

`endif

/* hdl/mkdb_pkg.sv */
// Shared types, constants and helpers for the multichannel ADC key debounce
`timescale 1ns / 1ps

package mkdb_pkg;

   localparam int CHANNELS_DEFAULT = 7;
   localparam int CHANNEL_W        = 3;
   localparam int SAMPLE_W         = 12;
   localparam int COUNT_W          = 4;
   localparam int CSR_DATA_W       = 12;

   localparam logic [SAMPLE_W-1:0] LOW_THRESHOLD_RESET   = 12'd2700;
   localparam logic [SAMPLE_W-1:0] VALID_THRESHOLD_RESET = 12'd3700;
   localparam logic [COUNT_W-1:0]  PRESS_COUNT_RESET     = 4'd2;
   localparam logic [COUNT_W-1:0]  RELEASE_COUNT_RESET   = 4'd2;

   typedef enum logic [1:0] {
      CSR_LOW_THRESHOLD   = 2'd0,
      CSR_VALID_THRESHOLD = 2'd1,
      CSR_PRESS_COUNT     = 2'd2,
      CSR_RELEASE_COUNT   = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [CHANNEL_W-1:0] channel;
      logic [SAMPLE_W-1:0]  sample;
   } req_type;

   typedef struct packed {
      logic [CHANNEL_W-1:0] channel_out;
      logic                 pressed;
      logic                 press_event;
      logic                 release_event;
      logic                 ignored;
   } rsp_type;

   // per-channel debounce state as held in the state memory
   typedef struct packed {
      logic               key_state;
      logic [COUNT_W-1:0] press_counter;
      logic [COUNT_W-1:0] release_counter;
   } entry_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] low_threshold;
      logic [SAMPLE_W-1:0] valid_threshold;
      logic [COUNT_W-1:0]  press_count;
      logic [COUNT_W-1:0]  release_count;
   } cfg_type;

   function automatic logic chan_in_range(logic [CHANNEL_W-1:0] ch, int channels);
      return int'(ch) < channels;
   endfunction

endpackage

/* hdl/mkdb_state_mem.sv */
// Per-channel state memory with valid bits and write-to-read forwarding
`timescale 1ns / 1ps

module mkdb_state_mem #(
   parameter int CHANNELS = mkdb_pkg::CHANNELS_DEFAULT,
   parameter int IDX_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 rd_en,
   input  logic [IDX_W-1:0]     rd_addr,
   input  logic                 wr_en,
   input  logic [IDX_W-1:0]     wr_addr,
   input  mkdb_pkg::entry_type  wr_data,
   output mkdb_pkg::entry_type  rd_data
);

   mkdb_pkg::entry_type mem [CHANNELS];
   mkdb_pkg::entry_type mem_q_ff;
   mkdb_pkg::entry_type fwd_data_ff;
   logic [CHANNELS-1:0] valid_ff;
   logic                rd_valid_ff;
   logic                fwd_hit_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         mem_q_ff    <= mem[rd_addr];
         fwd_data_ff <= wr_data;
      end
   end

   // entries never written read as zero (released, counters clear)
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
         fwd_hit_ff  <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_valid_ff <= valid_ff[rd_addr];
            fwd_hit_ff  <= wr_en && (wr_addr == rd_addr);
         end
      end
   end

   always_comb begin
      if (fwd_hit_ff) begin
         rd_data = fwd_data_ff;
      end else if (rd_valid_ff) begin
         rd_data = mem_q_ff;
      end else begin
         rd_data = '0;
      end
   end

endmodule

/* hdl/mkdb_update.sv */
// Debounce decision: classifies a sample and computes the new channel state
`timescale 1ns / 1ps

module mkdb_update #(
   parameter int CHANNELS = mkdb_pkg::CHANNELS_DEFAULT
) (
   input  mkdb_pkg::req_type    req,
   input  mkdb_pkg::entry_type  cur,
   input  mkdb_pkg::cfg_type    cfg,
   output logic                 wr_en,
   output mkdb_pkg::entry_type  nxt,
   output mkdb_pkg::rsp_type    rsp
);

   logic                          in_range;
   logic                          is_low;
   logic                          is_mid;
   logic [mkdb_pkg::COUNT_W-1:0]  pcnt;
   logic [mkdb_pkg::COUNT_W-1:0]  rcnt;

   always_comb begin
      in_range = mkdb_pkg::chan_in_range(req.channel, CHANNELS);
      is_low   = req.sample < cfg.low_threshold;
      is_mid   = !is_low && (req.sample <= cfg.valid_threshold);

      // counters saturate at their target
      pcnt = (cur.press_counter < cfg.press_count) ?
             cur.press_counter + 4'd1 : cur.press_counter;
      rcnt = (cur.release_counter < cfg.release_count) ?
             cur.release_counter + 4'd1 : cur.release_counter;

      nxt               = cur;
      rsp.channel_out   = req.channel;
      rsp.press_event   = 1'b0;
      rsp.release_event = 1'b0;
      rsp.ignored       = 1'b0;

      if (!in_range) begin
         rsp.ignored = 1'b1;
      end else if (is_low) begin
         if (!cur.key_state) begin
            nxt.press_counter = pcnt;
            if (pcnt >= cfg.press_count) begin
               nxt.key_state       = 1'b1;
               nxt.release_counter = '0;
               rsp.press_event     = 1'b1;
            end
         end else begin
            nxt.release_counter = '0;
         end
      end else if (is_mid) begin
         if (cur.key_state) begin
            nxt.release_counter = rcnt;
            if (rcnt >= cfg.release_count) begin
               nxt.key_state     = 1'b0;
               nxt.press_counter = '0;
               rsp.release_event = 1'b1;
            end
         end else begin
            nxt.press_counter = '0;
         end
      end else begin
         rsp.ignored = 1'b1;
      end

      rsp.pressed = in_range && nxt.key_state;
      wr_en       = in_range;
   end

endmodule

/* hdl/multichannel_adc_key_debounce.sv */
// Top level of the multichannel ADC key debounce block
`timescale 1ns / 1ps
`include "multichannel_adc_key_debounce_macros.svh"

// Channel   | Dir | Ports                          | Moves
// ----------+-----+--------------------------------+------------------------------
// request   | in  | req_valid, req_stall, req_data | channel + 12-bit sample
// response  | out | rsp_valid, rsp_stall, rsp_data | state, events, ignored flag
// csr       | in  | csr_wr_en, csr_index, csr_wdata| thresholds and debounce counts
//
// One request per cycle sustained unless the response stalls; the state memory is read
// as a request is taken, then update and write-back fill the response register.
// Same-channel requests back to back are handled by forwarding the write-back.
// Reset clears the valid bits of all state entries together; no clearing pass.
// A stalled response holds; the update stage behind it takes one more request
// before req_stall rises.

module multichannel_adc_key_debounce #(
   parameter int CHANNELS = mkdb_pkg::CHANNELS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  mkdb_pkg::req_type                 req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output mkdb_pkg::rsp_type                 rsp_data,
   input  logic                              csr_wr_en,
   input  mkdb_pkg::csr_index_type           csr_index,
   input  logic [mkdb_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   // configuration registers
   mkdb_pkg::cfg_type   cfg_ff;

   // update stage: request waiting on its memory read data
   logic                s1_valid_ff;
   logic                s1_valid_in;
   mkdb_pkg::req_type   s1_req_ff;

   // response register
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   mkdb_pkg::rsp_type   rsp_data_ff;

   logic                accept;
   logic                out_free;
   logic                advance;
   logic                rd_en;
   logic                wr_en;
   logic                upd_wr_en;
   mkdb_pkg::entry_type cur_entry;
   mkdb_pkg::entry_type nxt_entry;
   mkdb_pkg::rsp_type   upd_rsp;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = s1_valid_ff && out_free;
   assign req_stall = reset || (s1_valid_ff && !out_free);
   assign accept    = req_valid && !req_stall;

   // out-of-range channels never touch the memory
   assign rd_en = accept && mkdb_pkg::chan_in_range(req_data.channel, CHANNELS);
   assign wr_en = advance && upd_wr_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.low_threshold   <= mkdb_pkg::LOW_THRESHOLD_RESET;
         cfg_ff.valid_threshold <= mkdb_pkg::VALID_THRESHOLD_RESET;
         cfg_ff.press_count     <= mkdb_pkg::PRESS_COUNT_RESET;
         cfg_ff.release_count   <= mkdb_pkg::RELEASE_COUNT_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            mkdb_pkg::CSR_LOW_THRESHOLD: begin
               cfg_ff.low_threshold <= csr_wdata;
            end
            mkdb_pkg::CSR_VALID_THRESHOLD: begin
               cfg_ff.valid_threshold <= csr_wdata;
            end
            mkdb_pkg::CSR_PRESS_COUNT: begin
               cfg_ff.press_count <= csr_wdata[mkdb_pkg::COUNT_W-1:0];
            end
            mkdb_pkg::CSR_RELEASE_COUNT: begin
               cfg_ff.release_count <= csr_wdata[mkdb_pkg::COUNT_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end

      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_req_ff <= req_data;
      end
      if (advance) begin
         rsp_data_ff <= upd_rsp;
      end
   end

   mkdb_state_mem #(
      .CHANNELS (CHANNELS),
      .IDX_W    (IDX_W)
   ) u_state_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (rd_en),
      .rd_addr (IDX_W'(req_data.channel)),
      .wr_en   (wr_en),
      .wr_addr (IDX_W'(s1_req_ff.channel)),
      .wr_data (nxt_entry),
      .rd_data (cur_entry)
   );

   mkdb_update #(
      .CHANNELS (CHANNELS)
   ) u_update (
      .req   (s1_req_ff),
      .cur   (cur_entry),
      .cfg   (cfg_ff),
      .wr_en (upd_wr_en),
      .nxt   (nxt_entry),
      .rsp   (upd_rsp)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // an item leaving the update stage shows up as a response next cycle
   `MKDB_ASSERT_NEXT(a_advance_to_rsp, clock, reset, advance, rsp_valid)
   // a press event always leaves the channel pressed
   `MKDB_ASSERT_NOW(a_press_sets, clock, reset, rsp_valid && rsp_data.press_event,
                    rsp_data.pressed && !rsp_data.release_event)
   // a release event leaves it released, and such a response is never flagged ignored
   `MKDB_ASSERT_NOW(a_release_clears, clock, reset, rsp_valid && rsp_data.release_event,
                    !rsp_data.pressed && !rsp_data.ignored)

endmodule

/* tb/tb_multichannel_adc_key_debounce.sv */
// Self-checking testbench for the multichannel ADC key debounce block
`timescale 1ns / 1ps

module tb_multichannel_adc_key_debounce;

   localparam int N_CHANNELS   = mkdb_pkg::CHANNELS_DEFAULT;
   localparam int CHANNEL_BITS = mkdb_pkg::CHANNEL_W;
   localparam int SAMPLE_BITS  = mkdb_pkg::SAMPLE_W;
   localparam int COUNT_BITS   = mkdb_pkg::COUNT_W;
   localparam int CSR_BITS     = mkdb_pkg::CSR_DATA_W;
   localparam int LIMIT_CYCLES = 200000;
   localparam int PHASES       = 8;
   localparam int PHASE_ITEMS  = 100;

   logic                    clock;
   logic                    reset;
   logic                    req_valid;
   logic                    req_stall;
   mkdb_pkg::req_type       req_data;
   logic                    rsp_valid;
   logic                    rsp_stall;
   mkdb_pkg::rsp_type       rsp_data;
   logic                    csr_wr_en;
   mkdb_pkg::csr_index_type csr_index;
   logic [CSR_BITS-1:0]     csr_wdata;

   multichannel_adc_key_debounce #(
      .CHANNELS(N_CHANNELS)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // 10 ns clock
   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Debounce mirror: per-channel key state and the two run counters, plus the
   // register settings the block currently holds.
   mkdb_pkg::cfg_type      settings;
   logic                   key_down  [N_CHANNELS];
   logic [COUNT_BITS-1:0]  down_run  [N_CHANNELS];
   logic [COUNT_BITS-1:0]  up_run    [N_CHANNELS];

   mkdb_pkg::rsp_type pending_rsps[$];   // responses owed by the block, oldest first
   int      failures;
   int      cycle_count;
   bit      sender_gaps;
   bit      rsp_gaps;

   // Directed table: a row carries a typed-in response only where it is obvious
   typedef struct packed {
      logic              typed;
      mkdb_pkg::rsp_type want;
      mkdb_pkg::req_type req;
   } stim_row_type;

   stim_row_type stim_table[$];

   function automatic mkdb_pkg::rsp_type make_rsp(input logic [CHANNEL_BITS-1:0] ch,
                                                  input logic prs, input logic pev,
                                                  input logic rev, input logic ign);
      mkdb_pkg::rsp_type o;
      o.channel_out   = ch;
      o.pressed       = prs;
      o.press_event   = pev;
      o.release_event = rev;
      o.ignored       = ign;
      return o;
   endfunction

   function automatic void add_row(input logic [CHANNEL_BITS-1:0] ch,
                                   input logic [SAMPLE_BITS-1:0] s,
                                   input logic typed, input mkdb_pkg::rsp_type want);
      stim_row_type row;
      row.typed       = typed;
      row.want        = want;
      row.req.channel = ch;
      row.req.sample  = s;
      stim_table.push_back(row);
   endfunction

   // Debounce update for one sample; advances the mirrored state.
   function automatic mkdb_pkg::rsp_type debounce_sample(input mkdb_pkg::req_type r);
      mkdb_pkg::rsp_type o;
      int                ch;
      o             = '0;
      o.channel_out = r.channel;
      ch            = int'(r.channel);
      if (ch >= N_CHANNELS) begin
         o.ignored = 1'b1;
      end else if (r.sample < settings.low_threshold) begin
         if (!key_down[ch]) begin
            if (down_run[ch] < settings.press_count) down_run[ch] = down_run[ch] + 4'd1;
            // a target at or below the held count completes at once
            if (down_run[ch] >= settings.press_count) begin
               key_down[ch]  = 1'b1;
               up_run[ch]    = '0;
               o.press_event = 1'b1;
            end
         end else begin
            up_run[ch] = '0;
         end
      end else if (r.sample <= settings.valid_threshold) begin
         if (key_down[ch]) begin
            if (up_run[ch] < settings.release_count) up_run[ch] = up_run[ch] + 4'd1;
            if (up_run[ch] >= settings.release_count) begin
               key_down[ch]    = 1'b0;
               down_run[ch]    = '0;
               o.release_event = 1'b1;
            end
         end else begin
            down_run[ch] = '0;
         end
      end else begin
         // above valid, or anything from low up when the thresholds cross
         o.ignored = 1'b1;
      end
      if (ch < N_CHANNELS) o.pressed = key_down[ch];
      return o;
   endfunction

   // Sample in the key-down range, biased toward the threshold edge
   function automatic logic [SAMPLE_BITS-1:0] pressed_sample();
      if (settings.low_threshold == 0) return SAMPLE_BITS'($urandom_range(0, 4095));
      if ($urandom_range(0, 3) == 0) return settings.low_threshold - 1;
      return SAMPLE_BITS'($urandom_range(0, settings.low_threshold - 1));
   endfunction

   // Sample in the key-up range, hitting both inclusive bounds now and then
   function automatic logic [SAMPLE_BITS-1:0] released_sample();
      if (settings.low_threshold > settings.valid_threshold)
         return SAMPLE_BITS'($urandom_range(0, 4095));
      case ($urandom_range(0, 7))
         0: return settings.low_threshold;
         1: return settings.valid_threshold;
         default: return SAMPLE_BITS'($urandom_range(settings.low_threshold,
                                                      settings.valid_threshold));
      endcase
   endfunction

   // Drive one request; inputs move on the falling edge, the handshake is seen
   // on the rising edge. The owed response is queued when the request is taken.
   task automatic send_request(input mkdb_pkg::req_type r, input logic typed,
                               input mkdb_pkg::rsp_type want);
      mkdb_pkg::rsp_type mirror_rsp;
      if (sender_gaps && $urandom_range(0, 7) == 0) begin
         @(negedge clock);
         req_valid = 1'b0;
         repeat ($urandom_range(0, 10)) @(negedge clock);
      end
      @(negedge clock);
      req_valid = 1'b1;
      req_data  = r;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      mirror_rsp = debounce_sample(r);
      pending_rsps.push_back(typed ? want : mirror_rsp);
   endtask

   // Hold off requests until every owed response is back, then load all four
   // registers, one per cycle.
   task automatic apply_settings(input mkdb_pkg::cfg_type s);
      @(negedge clock);
      req_valid = 1'b0;
      while (pending_rsps.size() != 0) @(negedge clock);
      csr_wr_en = 1'b1;
      csr_index = mkdb_pkg::CSR_LOW_THRESHOLD;
      csr_wdata = s.low_threshold;
      @(negedge clock);
      csr_index = mkdb_pkg::CSR_VALID_THRESHOLD;
      csr_wdata = s.valid_threshold;
      @(negedge clock);
      csr_index = mkdb_pkg::CSR_PRESS_COUNT;
      csr_wdata = {{(CSR_BITS-COUNT_BITS){1'b0}}, s.press_count};
      @(negedge clock);
      csr_index = mkdb_pkg::CSR_RELEASE_COUNT;
      csr_wdata = {{(CSR_BITS-COUNT_BITS){1'b0}}, s.release_count};
      @(negedge clock);
      csr_wr_en = 1'b0;
      settings  = s;
   endtask

   // Mostly key-press / key-release runs of 1 to 17 samples on one channel, the longest
   // beating any count; the rest is stray samples on any channel, the unused one too.
   task automatic run_random_items(input int target);
      mkdb_pkg::req_type r;
      int      done;
      int      run_len;
      int      ch;
      bit      up_run_kind;
      done = 0;
      while (done < target) begin
         if ($urandom_range(0, 4) == 0) begin
            r.channel = CHANNEL_BITS'($urandom_range(0, 7));
            r.sample  = SAMPLE_BITS'($urandom_range(0, 4095));
            send_request(r, 1'b0, '0);
            done++;
         end else begin
            ch          = $urandom_range(0, N_CHANNELS - 1);
            up_run_kind = ($urandom_range(0, 1) != 0);
            run_len     = $urandom_range(1, 17);
            repeat (run_len) begin
               r.channel = CHANNEL_BITS'(ch);
               r.sample  = up_run_kind ? released_sample() : pressed_sample();
               // interleave another channel once in a while
               if ($urandom_range(0, 9) == 0)
                  r.channel = CHANNEL_BITS'($urandom_range(0, N_CHANNELS - 1));
               send_request(r, 1'b0, '0);
               done++;
            end
         end
      end
   endtask

   // Response side back-pressure: random stall bursts while rsp_gaps is set
   initial begin : stall_gen
      int hold;
      hold      = 0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold == 0 && rsp_gaps && $urandom_range(0, 7) == 0) hold = $urandom_range(1, 11);
         rsp_stall = (hold != 0);
         if (hold != 0) hold--;
      end
   end

   // Response checker: each accepted response against the oldest owed one
   always @(posedge clock) begin : check_rsps
      mkdb_pkg::rsp_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (pending_rsps.size() == 0) begin
            failures++;
            if (failures <= 10)
               $display("unexpected response: ch=%0d pr=%b pe=%b re=%b ig=%b",
                        rsp_data.channel_out, rsp_data.pressed, rsp_data.press_event,
                        rsp_data.release_event, rsp_data.ignored);
         end else begin
            want = pending_rsps.pop_front();
            if (rsp_data.channel_out   !== want.channel_out   ||
                rsp_data.pressed       !== want.pressed       ||
                rsp_data.press_event   !== want.press_event   ||
                rsp_data.release_event !== want.release_event ||
                rsp_data.ignored       !== want.ignored) begin
               failures++;
               if (failures <= 10)
                  $display({"mismatch: expected ch=%0d pr=%b pe=%b re=%b ig=%b, ",
                            "got ch=%0d pr=%b pe=%b re=%b ig=%b"},
                           want.channel_out, want.pressed, want.press_event,
                           want.release_event, want.ignored,
                           rsp_data.channel_out, rsp_data.pressed, rsp_data.press_event,
                           rsp_data.release_event, rsp_data.ignored);
            end
         end
      end
   end

   // Run watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin : main
      mkdb_pkg::cfg_type s;
      int      i;
      int      phase;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_data    = '0;
      csr_wr_en   = 1'b0;
      csr_index   = mkdb_pkg::CSR_LOW_THRESHOLD;
      csr_wdata   = '0;
      failures    = 0;
      cycle_count = 0;
      sender_gaps = 1'b1;
      rsp_gaps    = 1'b1;
      settings.low_threshold   = mkdb_pkg::LOW_THRESHOLD_RESET;
      settings.valid_threshold = mkdb_pkg::VALID_THRESHOLD_RESET;
      settings.press_count     = mkdb_pkg::PRESS_COUNT_RESET;
      settings.release_count   = mkdb_pkg::RELEASE_COUNT_RESET;
      for (i = 0; i < N_CHANNELS; i++) begin
         key_down[i] = 1'b0;
         down_run[i] = '0;
         up_run[i]   = '0;
      end

      // Directed rows, reset settings: low 2700, valid 3700, both counts 2
      add_row(3'd0, 12'd4095, 1'b1, make_rsp(3'd0, 1'b0, 1'b0, 1'b0, 1'b1)); // above valid
      add_row(3'd7, 12'd0,    1'b1, make_rsp(3'd7, 1'b0, 1'b0, 1'b0, 1'b1)); // channel out of range
      add_row(3'd0, 12'd0,    1'b1, make_rsp(3'd0, 1'b0, 1'b0, 1'b0, 1'b0)); // first low sample
      add_row(3'd0, 12'd2699, 1'b1, make_rsp(3'd0, 1'b1, 1'b1, 1'b0, 1'b0)); // press completes
      add_row(3'd0, 12'd2700, 1'b1, make_rsp(3'd0, 1'b1, 1'b0, 1'b0, 1'b0)); // low edge is key-up
      add_row(3'd0, 12'd3700, 1'b1, make_rsp(3'd0, 1'b0, 1'b0, 1'b1, 1'b0)); // release completes
      add_row(3'd0, 12'd3701, 1'b1, make_rsp(3'd0, 1'b0, 1'b0, 1'b0, 1'b1)); // just above valid
      add_row(3'd7, 12'd4095, 1'b1, make_rsp(3'd7, 1'b0, 1'b0, 1'b0, 1'b1));
      add_row(3'd6, 12'd0,    1'b0, '0);
      add_row(3'd6, 12'd100,  1'b0, '0);
      add_row(3'd6, 12'd0,    1'b0, '0);  // pressed and low: release run cleared
      add_row(3'd6, 12'd3000, 1'b0, '0);
      add_row(3'd6, 12'd1000, 1'b0, '0);  // breaks the release run
      add_row(3'd6, 12'd3000, 1'b0, '0);
      add_row(3'd6, 12'd3000, 1'b0, '0);
      add_row(3'd3, 12'd0,    1'b0, '0);
      add_row(3'd3, 12'd2800, 1'b0, '0);  // released and key-up: press run cleared
      add_row(3'd3, 12'd0,    1'b0, '0);
      add_row(3'd3, 12'd0,    1'b0, '0);
      add_row(3'd5, 12'hAAA,  1'b0, '0);
      add_row(3'd1, 12'h555,  1'b0, '0);
      add_row(3'd2, 12'd1,    1'b0, '0);
      add_row(3'd4, 12'd2,    1'b0, '0);

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (stim_table[k])
         send_request(stim_table[k].req, stim_table[k].typed, stim_table[k].want);

      // Register phases: extremes, a long-count phase followed by short counts
      // so held runs exceed the lowered target, crossed thresholds, random
      // settings, and finally the reset values with no idling at all.
      for (phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: s = {12'd0,    12'd0,    4'd0,  4'd0};
            1: s = {12'd4095, 12'd4095, 4'd15, 4'd15};
            2: s = {12'd1000, 12'd3000, 4'd15, 4'd15};
            3: s = {12'd1000, 12'd3000, 4'd1,  4'd1};
            4: s = {12'd3000, 12'd1000, 4'd3,  4'd2};
            7: s = {mkdb_pkg::LOW_THRESHOLD_RESET, mkdb_pkg::VALID_THRESHOLD_RESET,
                    mkdb_pkg::PRESS_COUNT_RESET, mkdb_pkg::RELEASE_COUNT_RESET};
            default: begin
               s.low_threshold   = SAMPLE_BITS'($urandom_range(0, 4095));
               s.valid_threshold = SAMPLE_BITS'($urandom_range(0, 4095));
               s.press_count     = COUNT_BITS'($urandom_range(0, 15));
               s.release_count   = COUNT_BITS'($urandom_range(0, 15));
            end
         endcase
         if (phase == PHASES - 1) begin
            sender_gaps = 1'b0;
            rsp_gaps    = 1'b0;
         end else begin
            sender_gaps = ($urandom_range(0, 3) != 0);
            rsp_gaps    = ($urandom_range(0, 3) != 0);
         end
         apply_settings(s);
         run_random_items(PHASE_ITEMS);
      end

      // Drain, then let any stray response show before the final verdict
      @(negedge clock);
      req_valid = 1'b0;
      while (pending_rsps.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      if (failures == 0 && pending_rsps.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
